FILE: rtl/ptw_pkg.sv
// ============================================================================
// ptw_pkg
// Shared types, codes and microcode program for the page table walker.
// ============================================================================
package ptw_pkg;

    localparam int DEF_TABLE_WORDS = 4096;
    localparam int DEF_LEVELS      = 4;

    localparam int VA_W    = 48;
    localparam int PA_W    = 48;
    localparam int WORD_W  = 64;
    localparam int WIDX_W  = 12;
    localparam int CFG_W   = 48;
    localparam int CFGA_W  = 2;
    localparam int LVL_W   = 3;
    localparam int SLOT_W  = 9;
    localparam int FAULT_W = 2;
    localparam int STEP_W  = 3;

    localparam logic [CFGA_W-1:0] CFG_TABLE_BASE    = 2'd0;
    localparam logic [CFGA_W-1:0] CFG_LEAF_BIT      = 2'd1;
    localparam logic [CFGA_W-1:0] CFG_LEAF_WHEN_SET = 2'd2;

    localparam logic [FAULT_W-1:0] FAULT_NONE        = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_NOT_PRESENT = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_RANGE       = 2'd2;

    localparam logic CMD_WRITE = 1'b0;

    typedef struct packed {
        logic                cmd;
        logic [WIDX_W-1:0]   word_index;
        logic [WORD_W-1:0]   entry_word;
        logic [VA_W-1:0]     vaddr;
    } req_t;

    typedef struct packed {
        logic                translated;
        logic [PA_W-1:0]     paddr;
        logic [FAULT_W-1:0]  fault_kind;
    } rsp_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        OP_ACCEPT = 3'd0,
        OP_WRITE  = 3'd1,
        OP_CHECK  = 3'd2,
        OP_EVAL   = 3'd3,
        OP_EMIT   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        C_ALWAYS    = 2'd0,
        C_CMD_WRITE = 2'd1,
        C_FIN       = 2'd2
    } cond_t;

    typedef struct packed {
        op_t    op;
        cond_t  cond;
        step_t  jump_t;
        step_t  jump_f;
    } uword_t;

    localparam step_t ST_ACCEPT = 3'd0;
    localparam step_t ST_CHECK  = 3'd1;
    localparam step_t ST_EVAL   = 3'd2;
    localparam step_t ST_WRITE  = 3'd3;
    localparam step_t ST_EMIT   = 3'd4;

    function automatic uword_t ucode(input step_t step);
        uword_t w;
        unique case (step)
            ST_ACCEPT: w = '{OP_ACCEPT, C_CMD_WRITE, ST_WRITE,  ST_CHECK};
            ST_CHECK:  w = '{OP_CHECK,  C_FIN,       ST_EMIT,   ST_EVAL};
            ST_EVAL:   w = '{OP_EVAL,   C_FIN,       ST_EMIT,   ST_CHECK};
            ST_WRITE:  w = '{OP_WRITE,  C_ALWAYS,    ST_EMIT,   ST_EMIT};
            ST_EMIT:   w = '{OP_EMIT,   C_ALWAYS,    ST_ACCEPT, ST_ACCEPT};
            default:   w = '{OP_EMIT,   C_ALWAYS,    ST_ACCEPT, ST_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/ptw_ram.sv
// ============================================================================
// ptw_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/four_level_page_table_walker_core.sv
// ============================================================================
// four_level_page_table_walker_core
// Page table walker over a local table store, driven by a microcoded
// sequencer.
// ============================================================================
// Usage:
//   req channel (valid/ready) carries write or translate requests; rsp
//   channel (valid/ready) returns one response per request. cfg_we writes
//   table_base (0), leaf_bit (1) or leaf_when_set (2); the user must do so only
//   while the block is idle, as the block itself does not enforce it. A write
//   request steps through accept, store write and response load. A translate
//   request reads up to LEVELS table words: each level has a step forming and
//   range-checking the table word address, then a step on the table memory's
//   registered read. A table address outside the store ends the walk after
//   its check, with no read.
//   The next request is accepted in the cycle after the response is loaded.
//   The response sits in an output register; a stalled receiver holds it
//   while the next request is accepted and walked, and only the next
//   response load waits for rsp_ready.
//   Reset clears the sequencer, the response valid flag and the config
//   registers (table_base 0, leaf_bit 7, leaf_when_set 1). The table store
//   is not cleared; translate only through words already written.
// ============================================================================
module four_level_page_table_walker_core #(
    parameter int TABLE_WORDS = ptw_pkg::DEF_TABLE_WORDS,
    parameter int LEVELS      = ptw_pkg::DEF_LEVELS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ptw_pkg::CFGA_W-1:0]  cfg_addr,
    input  logic [ptw_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  ptw_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output ptw_pkg::rsp_t               rsp
);

    import ptw_pkg::*;

    localparam int AW = $clog2(TABLE_WORDS);
    localparam int WW = VA_W - 2;

    localparam logic [WW-1:0] TW_LIMIT = WW'(TABLE_WORDS);

    logic [VA_W-1:0]     base_reg;
    logic [5:0]          leaf_bit_reg;
    logic                leaf_pol_reg;

    step_t               step_reg, step_next;
    uword_t              uw;
    logic                hold;
    logic                jump;
    logic                fin;
    logic                req_fire;

    logic [VA_W-1:0]     va_reg;
    logic [WIDX_W-1:0]   widx_reg;
    logic [WORD_W-1:0]   wdata_reg;
    logic [PA_W-1:0]     addr_reg, addr_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic                ok_reg, ok_next;
    logic [FAULT_W-1:0]  fault_reg, fault_next;
    logic                xlate_reg;

    rsp_t                rsp_reg;
    logic                rsp_valid_reg;

    logic [SLOT_W-1:0]   slot;
    logic [PA_W-1:0]     rel;
    logic [WW-1:0]       word;
    logic                out_of_range;
    logic [PA_W-1:0]     off_mask;
    logic [PA_W-1:0]     pa_sum;
    logic [WW-1:0]       widx_wide;
    logic                widx_ok;

    logic                mem_we;
    logic                mem_re;
    logic [WORD_W-1:0]   entry;
    logic                leaf;

    assign uw        = ucode(step_reg);
    assign req_ready = (uw.op == OP_ACCEPT);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        unique case (lvl_reg)
            3'd4:    slot = va_reg[47:39];
            3'd3:    slot = va_reg[38:30];
            3'd2:    slot = va_reg[29:21];
            default: slot = va_reg[20:12];
        endcase
    end

    always_comb
    begin
        unique case (lvl_reg)
            3'd4:    off_mask = {{9{1'b0}},  {39{1'b1}}};
            3'd3:    off_mask = {{18{1'b0}}, {30{1'b1}}};
            3'd2:    off_mask = {{27{1'b0}}, {21{1'b1}}};
            default: off_mask = {{36{1'b0}}, {12{1'b1}}};
        endcase
    end

    assign rel          = addr_reg - base_reg;
    assign word         = WW'(rel[PA_W-1:3]) + WW'(slot);
    assign out_of_range = (addr_reg < base_reg) || (word >= TW_LIMIT);
    assign widx_wide    = WW'(widx_reg);
    assign widx_ok      = (widx_wide < TW_LIMIT);
    assign leaf         = (entry[leaf_bit_reg] == leaf_pol_reg);
    assign pa_sum       = addr_reg + (va_reg & off_mask);

    assign mem_we = (uw.op == OP_WRITE) && widx_ok;
    assign mem_re = (uw.op == OP_CHECK) && !out_of_range;

    ptw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (widx_wide[AW-1:0]),
        .wdata (wdata_reg),
        .re    (mem_re),
        .raddr (word[AW-1:0]),
        .rdata (entry)
    );

    always_comb
    begin
        addr_next  = addr_reg;
        lvl_next   = lvl_reg;
        ok_next    = ok_reg;
        fault_next = fault_reg;
        fin        = 1'b0;
        hold       = 1'b0;
        unique case (uw.op)
            OP_ACCEPT:
            begin
                hold       = !req_fire;
                addr_next  = base_reg;
                lvl_next   = LVL_W'(LEVELS);
                ok_next    = 1'b1;
                fault_next = FAULT_NONE;
            end
            OP_WRITE:
            begin
                ok_next    = widx_ok;
                fault_next = widx_ok ? FAULT_NONE : FAULT_RANGE;
            end
            OP_CHECK:
            begin
                if (out_of_range)
                begin
                    fin        = 1'b1;
                    ok_next    = 1'b0;
                    fault_next = FAULT_RANGE;
                end
            end
            OP_EVAL:
            begin
                if (!entry[0])
                begin
                    fin        = 1'b1;
                    ok_next    = 1'b0;
                    fault_next = FAULT_NOT_PRESENT;
                end
                else
                begin
                    addr_next = {entry[47:12], 12'h000};
                    if (leaf)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        lvl_next = lvl_reg - 1'b1;
                        fin      = (lvl_reg == LVL_W'(1));
                    end
                end
            end
            OP_EMIT:
            begin
                hold = rsp_valid_reg && !rsp_ready;
            end
            default:
            begin
                hold = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (uw.cond)
            C_ALWAYS:    jump = 1'b1;
            C_CMD_WRITE: jump = (req.cmd == CMD_WRITE);
            C_FIN:       jump = fin;
            default:     jump = 1'b1;
        endcase
        if (hold)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = jump ? uw.jump_t : uw.jump_f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_ACCEPT;
            rsp_valid_reg <= 1'b0;
            base_reg      <= '0;
            leaf_bit_reg  <= 6'd7;
            leaf_pol_reg  <= 1'b1;
        end
        else
        begin
            step_reg <= step_next;
            if (uw.op == OP_EMIT && !hold)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_TABLE_BASE:    base_reg     <= cfg_wdata[VA_W-1:0];
                    CFG_LEAF_BIT:      leaf_bit_reg <= cfg_wdata[5:0];
                    CFG_LEAF_WHEN_SET: leaf_pol_reg <= cfg_wdata[0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            va_reg    <= req.vaddr;
            widx_reg  <= req.word_index;
            wdata_reg <= req.entry_word;
            xlate_reg <= (req.cmd != CMD_WRITE);
        end
        if (!hold)
        begin
            addr_reg  <= addr_next;
            lvl_reg   <= lvl_next;
            ok_reg    <= ok_next;
            fault_reg <= fault_next;
        end
        if (uw.op == OP_EMIT && !hold)
        begin
            rsp_reg.translated <= ok_reg;
            rsp_reg.paddr      <= (ok_reg && xlate_reg) ? pa_sum : '0;
            rsp_reg.fault_kind <= fault_reg;
        end
    end

endmodule
